[src/awbs_pkg.sv]
// shared types and constants for the affine warp bilinear sampler
// no dependencies; imported by every module of the block

package awbs_pkg;

	// source store geometry
	localparam int SRC_MAX_SIDE = 256;
	localparam int DST_MAX_SIDE = 128;
	localparam int SIDE_W       = $clog2(SRC_MAX_SIDE);
	localparam int HALF_W       = SIDE_W - 1;
	localparam int NUM_BANKS    = 4;
	localparam int BANK_SEL_W   = 2;
	localparam int BANK_AW      = 2 * HALF_W;
	localparam int BANK_DEPTH   = 1 << BANK_AW;

	// pixel and channel sizes
	localparam int CH_W     = 8;
	localparam int NUM_CH   = 3;
	localparam int PIX_W    = NUM_CH * CH_W;
	localparam int NUM_NBR  = 4;

	// configuration port
	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int DIM_W     = 9;

	localparam logic [CFG_IDX_W-1:0] REG_INV_A      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INV_B      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_INV_C      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_INV_D      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INV_E      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_INV_F      = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 3'd7;

	localparam logic [CFG_W-1:0] COEF_ONE = 32'h0001_0000;

	// coordinate arithmetic
	localparam int FRAC_BITS   = 16;
	localparam int PROD_W      = CFG_W + SIDE_W + 1;
	localparam int U_W         = PROD_W + 2;
	localparam int WEIGHT_DROP = 5;
	localparam int WEIGHT_W    = FRAC_BITS + 1 - WEIGHT_DROP;
	localparam int WEIGHT_ONE  = 1 << (WEIGHT_W - 1);
	localparam int BLEND_SHIFT = 2 * (WEIGHT_W - 1);
	localparam int PW_W        = CH_W + WEIGHT_W;
	localparam int PWW_W       = PW_W + WEIGHT_W;

	typedef struct packed {
		logic              mode;
		logic [SIDE_W-1:0] col;
		logic [SIDE_W-1:0] row;
		logic [CH_W-1:0]   in_ch0;
		logic [CH_W-1:0]   in_ch1;
		logic [CH_W-1:0]   in_ch2;
	} in_beat_t;

	typedef struct packed {
		logic [CH_W-1:0] out_ch0;
		logic [CH_W-1:0] out_ch1;
		logic [CH_W-1:0] out_ch2;
		logic            inside_res;
	} out_beat_t;

	// store access issued by the address stage
	typedef struct packed {
		logic                                wr;
		logic [BANK_SEL_W-1:0]               wbank;
		logic [BANK_AW-1:0]                  waddr;
		logic [PIX_W-1:0]                    wdata;
		logic [NUM_BANKS-1:0][BANK_AW-1:0]   raddr;
	} mem_req_t;

	// per-request control handed to the blend stages
	typedef struct packed {
		logic                res;
		logic                hit;
		logic                sx0;
		logic                sy0;
		logic [WEIGHT_W-1:0] wx0;
		logic [WEIGHT_W-1:0] wx1;
		logic [WEIGHT_W-1:0] wy0;
		logic [WEIGHT_W-1:0] wy1;
	} tag_t;

endpackage

[src/awbs_store.sv]
// four-bank interleaved source image store, bank picked by row and column parity
// depends on awbs_pkg; one write and four reads per cycle while en is high, read data registered

module awbs_store import awbs_pkg::*; (
	input  logic                                clk,
	input  logic                                en,
	input  mem_req_t                            req,
	output logic [NUM_BANKS-1:0][PIX_W-1:0]     rdata
);

	for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
		logic [PIX_W-1:0] mem [BANK_DEPTH];
		logic [PIX_W-1:0] rd_q;

		always_ff @(posedge clk) begin
			if (en && req.wr && req.wbank == BANK_SEL_W'(b)) begin
				mem[req.waddr] <= req.wdata;
			end
			if (en) begin
				rd_q <= mem[req.raddr[b]];
			end
		end

		assign rdata[b] = rd_q;
	end

endmodule

[src/awbs_map.sv]
// configuration registers and the coordinate stages: products, sums,
// bounds check, weights and bank addresses; depends on awbs_pkg

module awbs_map import awbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 adv,
	input  logic                 in_valid,
	input  in_beat_t             in_data,
	output mem_req_t             mem_req,
	output tag_t                 tag
);

	logic signed [CFG_W-1:0] inv_a_q, inv_b_q, inv_c_q, inv_d_q, inv_e_q, inv_f_q;
	logic [DIM_W-1:0]        src_width_q, src_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_a_q      <= COEF_ONE;
			inv_b_q      <= '0;
			inv_c_q      <= '0;
			inv_d_q      <= '0;
			inv_e_q      <= COEF_ONE;
			inv_f_q      <= '0;
			src_width_q  <= DIM_W'(SRC_MAX_SIDE);
			src_height_q <= DIM_W'(SRC_MAX_SIDE);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_INV_A:      inv_a_q      <= cfg_data;
				REG_INV_B:      inv_b_q      <= cfg_data;
				REG_INV_C:      inv_c_q      <= cfg_data;
				REG_INV_D:      inv_d_q      <= cfg_data;
				REG_INV_E:      inv_e_q      <= cfg_data;
				REG_INV_F:      inv_f_q      <= cfg_data;
				REG_SRC_WIDTH:  src_width_q  <= cfg_data[DIM_W-1:0];
				REG_SRC_HEIGHT: src_height_q <= cfg_data[DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// stage 1: four coefficient products
	logic signed [PROD_W-1:0] x_ext, y_ext;
	logic signed [PROD_W-1:0] ax_s1, by_s1, dx_s1, ey_s1;
	logic                     valid_s1, mode_s1, dst_ok_s1;
	logic [SIDE_W-1:0]        col_s1, row_s1;
	logic [PIX_W-1:0]         pix_s1;

	assign x_ext = $signed(PROD_W'(in_data.col));
	assign y_ext = $signed(PROD_W'(in_data.row));

	// stage 2: source coordinates in signed Q27.16 (U_W bits, 16 fraction bits)
	logic signed [U_W-1:0] u_s2, v_s2;
	logic                  valid_s2, mode_s2, dst_ok_s2;
	logic [SIDE_W-1:0]     col_s2, row_s2;
	logic [PIX_W-1:0]      pix_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mode_s1   <= in_data.mode;
			col_s1    <= in_data.col;
			row_s1    <= in_data.row;
			pix_s1    <= {in_data.in_ch2, in_data.in_ch1, in_data.in_ch0};
			dst_ok_s1 <= (32'(in_data.col) < DST_MAX_SIDE) && (32'(in_data.row) < DST_MAX_SIDE);
			ax_s1     <= PROD_W'(inv_a_q) * x_ext;
			by_s1     <= PROD_W'(inv_b_q) * y_ext;
			dx_s1     <= PROD_W'(inv_d_q) * x_ext;
			ey_s1     <= PROD_W'(inv_e_q) * y_ext;

			mode_s2   <= mode_s1;
			col_s2    <= col_s1;
			row_s2    <= row_s1;
			pix_s2    <= pix_s1;
			dst_ok_s2 <= dst_ok_s1;
			u_s2      <= U_W'(ax_s1) + U_W'(by_s1) + U_W'(inv_c_q);
			v_s2      <= U_W'(dx_s1) + U_W'(ey_s1) + U_W'(inv_f_q);
		end
	end

	// stage 3: cell, bounds, weights, store access
	logic [SIDE_W-1:0]   sx, sy;
	logic [DIM_W-1:0]    w_eff, h_eff;
	logic                cell_ok;
	logic [FRAC_BITS:0]  rem_u, rem_v;
	logic [NUM_BANKS-1:0][BANK_AW-1:0] raddr_c;

	always_comb begin
		logic [HALF_W-1:0] rr, cc;
		logic [BANK_SEL_W-1:0] bs;
		sx    = u_s2[FRAC_BITS +: SIDE_W];
		sy    = v_s2[FRAC_BITS +: SIDE_W];
		w_eff = (src_width_q > DIM_W'(SRC_MAX_SIDE)) ? DIM_W'(SRC_MAX_SIDE) : src_width_q;
		h_eff = (src_height_q > DIM_W'(SRC_MAX_SIDE)) ? DIM_W'(SRC_MAX_SIDE) : src_height_q;
		// sign bit sits in the high part, so a zero high part also means non-negative
		cell_ok = (u_s2[U_W-1:FRAC_BITS+SIDE_W] == '0)
			&& (v_s2[U_W-1:FRAC_BITS+SIDE_W] == '0)
			&& ((DIM_W'(sx) + DIM_W'(1)) < w_eff)
			&& ((DIM_W'(sy) + DIM_W'(1)) < h_eff);
		rem_u = (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(u_s2[FRAC_BITS-1:0]);
		rem_v = (FRAC_BITS+1)'(1 << FRAC_BITS) - (FRAC_BITS+1)'(v_s2[FRAC_BITS-1:0]);
		// even-parity bank of an odd coordinate holds the next row or column
		for (int b = 0; b < NUM_BANKS; b++) begin
			bs = BANK_SEL_W'(b);
			rr = bs[1] ? sy[SIDE_W-1:1] : HALF_W'(sy[SIDE_W-1:1] + HALF_W'(sy[0]));
			cc = bs[0] ? sx[SIDE_W-1:1] : HALF_W'(sx[SIDE_W-1:1] + HALF_W'(sx[0]));
			raddr_c[b] = {rr, cc};
		end
	end

	logic res_s3, wr_s3, inside_s3;
	logic                  sx0_s3, sy0_s3;
	logic [WEIGHT_W-1:0]   wx0_s3, wx1_s3, wy0_s3, wy1_s3;
	logic [BANK_SEL_W-1:0] wbank_s3;
	logic [BANK_AW-1:0]    waddr_s3;
	logic [PIX_W-1:0]      wdata_s3;
	logic [NUM_BANKS-1:0][BANK_AW-1:0] raddr_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s3    <= 1'b0;
			wr_s3     <= 1'b0;
			inside_s3 <= 1'b0;
		end else if (adv) begin
			res_s3    <= valid_s2 && mode_s2;
			wr_s3     <= valid_s2 && !mode_s2;
			inside_s3 <= valid_s2 && mode_s2 && dst_ok_s2 && cell_ok;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sx0_s3   <= sx[0];
			sy0_s3   <= sy[0];
			wx0_s3   <= rem_u[FRAC_BITS -: WEIGHT_W];
			wx1_s3   <= WEIGHT_W'(WEIGHT_ONE) - rem_u[FRAC_BITS -: WEIGHT_W];
			wy0_s3   <= rem_v[FRAC_BITS -: WEIGHT_W];
			wy1_s3   <= WEIGHT_W'(WEIGHT_ONE) - rem_v[FRAC_BITS -: WEIGHT_W];
			wbank_s3 <= {row_s2[0], col_s2[0]};
			waddr_s3 <= {row_s2[SIDE_W-1:1], col_s2[SIDE_W-1:1]};
			wdata_s3 <= pix_s2;
			raddr_s3 <= raddr_c;
		end
	end

	assign tag.res = res_s3;
	assign tag.hit = inside_s3;
	assign tag.sx0 = sx0_s3;
	assign tag.sy0 = sy0_s3;
	assign tag.wx0 = wx0_s3;
	assign tag.wx1 = wx1_s3;
	assign tag.wy0 = wy0_s3;
	assign tag.wy1 = wy1_s3;

	assign mem_req.wr    = wr_s3;
	assign mem_req.wbank = wbank_s3;
	assign mem_req.waddr = waddr_s3;
	assign mem_req.wdata = wdata_s3;
	assign mem_req.raddr = raddr_s3;

	a_inside_is_request: assert property (@(posedge clk) disable iff (!arst_n)
		inside_s3 |-> res_s3)
		else $error("inside flag set on a beat that is not a request");

	a_write_not_request: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_s3 && res_s3))
		else $error("stage 3 beat is both a write and a request");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		adv && in_valid |=> valid_s1)
		else $error("accepted beat missing from stage 1");

endmodule

[src/awbs_blend.sv]
// bilinear blend: neighbour select, two weight multiplies, channel sums,
// output register and pipeline advance; depends on awbs_pkg

module awbs_blend import awbs_pkg::*; (
	input  logic                            clk,
	input  logic                            arst_n,
	input  tag_t                            tag,
	input  logic [NUM_BANKS-1:0][PIX_W-1:0] rdata,
	input  logic                            out_stall,
	output logic                            adv,
	output logic                            out_valid,
	output out_beat_t                       out_data
);

	logic res_s4, res_s5, res_s6;
	logic out_valid_q;
	out_beat_t out_q;
	logic out_free;

	// stage 4 holds the tag aligned with the registered store data
	tag_t tag_s4;

	logic [NUM_NBR-1:0][NUM_CH-1:0][PW_W-1:0]  pw_s5;
	logic [WEIGHT_W-1:0]                       wy0_s5, wy1_s5;
	logic                                      inside_s5;
	logic [NUM_NBR-1:0][NUM_CH-1:0][PWW_W-1:0] pww_s6;
	logic                                      inside_s6;

	assign out_free = !out_valid_q || !out_stall;
	assign adv      = out_free || !res_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s4 <= 1'b0;
			res_s5 <= 1'b0;
			res_s6 <= 1'b0;
		end else if (adv) begin
			res_s4 <= tag.res;
			res_s5 <= res_s4;
			res_s6 <= res_s5;
		end
	end

	// neighbour (dy,dx) of cell (sx,sy) lives in bank {sy0^dy, sx0^dx}
	always_ff @(posedge clk) begin
		logic [BANK_SEL_W-1:0] kk;
		logic [BANK_SEL_W-1:0] bsel;
		logic [PIX_W-1:0]      pix;
		logic [WEIGHT_W-1:0]   wx, wy;
		if (adv) begin
			tag_s4    <= tag;
			wy0_s5    <= tag_s4.wy0;
			wy1_s5    <= tag_s4.wy1;
			inside_s5 <= tag_s4.hit;
			inside_s6 <= inside_s5;
			for (int k = 0; k < NUM_NBR; k++) begin
				kk   = BANK_SEL_W'(k);
				bsel = {tag_s4.sy0 ^ kk[1], tag_s4.sx0 ^ kk[0]};
				pix  = rdata[bsel];
				wx   = kk[0] ? tag_s4.wx1 : tag_s4.wx0;
				wy   = kk[1] ? wy1_s5 : wy0_s5;
				for (int c = 0; c < NUM_CH; c++) begin
					pw_s5[k][c]  <= PW_W'(pix[c*CH_W +: CH_W]) * PW_W'(wx);
					pww_s6[k][c] <= PWW_W'(pw_s5[k][c]) * PWW_W'(wy);
				end
			end
		end
	end

	// channel sums stay below 2^30, so no wrap before the shift
	logic [NUM_CH-1:0][CH_W-1:0] ch_c;

	always_comb begin
		logic [PWW_W-1:0] acc;
		for (int c = 0; c < NUM_CH; c++) begin
			acc = '0;
			for (int k = 0; k < NUM_NBR; k++) begin
				acc = acc + pww_s6[k][c];
			end
			ch_c[c] = inside_s6 ? acc[BLEND_SHIFT +: CH_W] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= res_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			out_q.out_ch0    <= ch_c[0];
			out_q.out_ch1    <= ch_c[1];
			out_q.out_ch2    <= ch_c[2];
			out_q.inside_res <= inside_s6;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_outside_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.inside_res |->
			out_q.out_ch0 == '0 && out_q.out_ch1 == '0 && out_q.out_ch2 == '0)
		else $error("outside result carries nonzero channels");

	a_freeze_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(res_s6) && $stable(res_s5) && $stable(res_s4))
		else $error("pipeline moved while frozen");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(res_s6))
		else $error("result beat appeared without a request in the last stage");

endmodule

[src/affine_warp_bilinear_sampler.sv]
// affine warp sampler: an accepted beat passes stages 1 to 6 and the output register before result valid,
// one beat per cycle sustained while the pipeline is not stalled, writes and requests mixed freely in any order
// throughput is set by the four-bank store giving all neighbours in one read
// the pipeline stalls as a whole only while a result waits in the output register
// reset clears valid bits and loads the identity map with a 256x256 image size;
// store contents are undefined after reset and need no clearing pass

module affine_warp_bilinear_sampler import awbs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_beat_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_beat_t            out_data
);

	logic                            adv;
	mem_req_t                        mem_req;
	tag_t                            tag;
	logic [NUM_BANKS-1:0][PIX_W-1:0] rdata;

	assign in_stall = !adv;

	awbs_map u_map (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.adv       (adv),
		.in_valid  (in_valid),
		.in_data   (in_data),
		.mem_req   (mem_req),
		.tag       (tag)
	);

	awbs_store u_store (
		.clk   (clk),
		.en    (adv),
		.req   (mem_req),
		.rdata (rdata)
	);

	awbs_blend u_blend (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag       (tag),
		.rdata     (rdata),
		.out_stall (out_stall),
		.adv       (adv),
		.out_valid (out_valid),
		.out_data  (out_data)
	);

endmodule
